// File: hw/rtl/monochrome_page_framebuffer_top_macros.svh
// assertion macros used by the checker file
`ifndef MONOCHROME_PAGE_FRAMEBUFFER_TOP_MACROS_SVH
`define MONOCHROME_PAGE_FRAMEBUFFER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MPFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MPFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mpfb_pkg.sv
package mpfb_pkg;

    localparam int COLUMNS     = 128;
    localparam int PAGES       = 8;
    localparam int ROWS        = 8 * PAGES;
    localparam int STORE_SIZE  = COLUMNS * PAGES;
    localparam int ADDR_W      = $clog2(STORE_SIZE);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int STEP_W      = $clog2(COLUMNS + 3);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [6:0] CTRL_CMD      = 7'h00;
    localparam logic [6:0] CTRL_DATA     = 7'h40;

    typedef enum logic [1:0] {
        MODE_DRAW    = 2'd0,
        MODE_CLEAR   = 2'd1,
        MODE_BITMAP  = 2'd2,
        MODE_REFRESH = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OP_SET_BIT,
        OP_CLR_BIT,
        OP_WRITE_BYTE,
        OP_CLEAR,
        OP_EMIT_CMD,
        OP_EMIT_DATA
    } t_op;

    // data holds the byte to write, the command byte, or the bit index
    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              last;
    } t_cmd;

    function automatic logic [7:0] reverse_byte(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/mpfb_in_if.sv
interface mpfb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] dot;
    logic [2:0] page;
    logic [7:0] bitmap_byte;

    modport source (output valid, mode, x, y, dot, page, bitmap_byte, input ready);
    modport sink (input valid, mode, x, y, dot, page, bitmap_byte, output ready);
endinterface

// File: hw/rtl/mpfb_out_if.sv
interface mpfb_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] control_byte;
    logic [7:0] value;
    logic       frame_end;

    modport source (output valid, control_byte, value, frame_end, input ready);
    modport sink (input valid, control_byte, value, frame_end, output ready);
endinterface

// File: hw/rtl/mpfb_front.sv
module mpfb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mpfb_in_if.sink        i_in,
    input  logic           i_full,
    input  logic           i_init_busy,
    output logic           o_push,
    output mpfb_pkg::t_cmd o_cmd
);
    import mpfb_pkg::*;

    logic [PAGE_W-1:0] r_page, n_page;
    logic [STEP_W-1:0] r_step, n_step;
    logic              accept;
    logic [COL_W-1:0]  col;

    assign i_in.ready = !i_full && !i_init_busy;
    assign accept     = i_in.valid && i_in.ready;
    assign col        = COL_W'(r_step - STEP_W'(3));

    always_comb begin
        n_page = r_page;
        n_step = r_step;
        o_push = 1'b0;
        o_cmd  = '{op: OP_WRITE_BYTE, addr: '0, data: '0, last: 1'b0};
        unique case (t_mode'(i_in.mode))
            MODE_DRAW: begin
                if (int'(i_in.x) < COLUMNS && int'(i_in.y) < ROWS &&
                    (i_in.dot == 8'd0 || i_in.dot == 8'd1)) begin
                    o_push     = accept;
                    o_cmd.op   = (i_in.dot == 8'd1) ? OP_SET_BIT : OP_CLR_BIT;
                    o_cmd.addr = ADDR_W'(int'(i_in.y[7:3]) * COLUMNS + int'(i_in.x));
                    o_cmd.data = {5'b0, i_in.y[2:0]};
                end
            end
            MODE_CLEAR: begin
                o_push   = accept;
                o_cmd.op = OP_CLEAR;
            end
            MODE_BITMAP: begin
                if (int'(i_in.x) < COLUMNS && int'(i_in.page) < PAGES) begin
                    o_push     = accept;
                    o_cmd.addr = ADDR_W'(int'(i_in.page) * COLUMNS + int'(i_in.x));
                    o_cmd.data = reverse_byte(i_in.bitmap_byte);
                end
            end
            MODE_REFRESH: begin
                o_push = accept;
                if (r_step == STEP_W'(0)) begin
                    o_cmd.op   = OP_EMIT_CMD;
                    o_cmd.data = 8'(int'(CMD_PAGE_BASE) + int'(r_page));
                end else if (r_step == STEP_W'(1)) begin
                    o_cmd.op   = OP_EMIT_CMD;
                    o_cmd.data = CMD_COL_HIGH;
                end else if (r_step == STEP_W'(2)) begin
                    o_cmd.op   = OP_EMIT_CMD;
                    o_cmd.data = CMD_COL_LOW;
                end else begin
                    o_cmd.op   = OP_EMIT_DATA;
                    o_cmd.addr = ADDR_W'(int'(r_page) * COLUMNS + int'(col));
                    o_cmd.last = (int'(col) == COLUMNS - 1) && (int'(r_page) == PAGES - 1);
                end
                if (accept) begin
                    if (int'(r_step) >= COLUMNS + 2) begin
                        n_step = '0;
                        n_page = (int'(r_page) == PAGES - 1) ? '0 : PAGE_W'(int'(r_page) + 1);
                    end else begin
                        n_step = r_step + STEP_W'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= '0;
            r_step <= '0;
        end else begin
            r_page <= n_page;
            r_step <= n_step;
        end
    end

endmodule

// File: hw/rtl/mpfb_queue.sv
module mpfb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mpfb_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output mpfb_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import mpfb_pkg::*;

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/mpfb_back.sv
module mpfb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mpfb_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_init_busy,
    mpfb_out_if.source     o_out
);
    import mpfb_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PIX,
        S_DATA
    } t_state;

    logic [7:0]        mem [STORE_SIZE];
    logic [7:0]        r_rd_data;

    t_state            r_state, n_state;
    logic              r_init, n_init;
    logic [ADDR_W-1:0] r_clr_cnt, n_clr_cnt;
    t_cmd              r_cmd, n_cmd;
    logic              r_out_valid, n_out_valid;
    logic [6:0]        r_out_ctrl, n_out_ctrl;
    logic [7:0]        r_out_value, n_out_value;
    logic              r_out_end, n_out_end;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              out_free;
    logic              is_emit;
    logic [7:0]        bit_mask;

    assign out_free    = !r_out_valid || o_out.ready;
    assign is_emit     = (i_cmd.op == OP_EMIT_CMD) || (i_cmd.op == OP_EMIT_DATA);
    assign o_pop       = (r_state == S_IDLE) && i_valid && (!is_emit || out_free);
    assign o_init_busy = r_init;
    assign bit_mask    = 8'd1 << r_cmd.data[2:0];

    assign o_out.valid        = r_out_valid;
    assign o_out.control_byte = r_out_ctrl;
    assign o_out.value        = r_out_value;
    assign o_out.frame_end    = r_out_end;

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_clr_cnt   = r_clr_cnt;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_ctrl  = r_out_ctrl;
        n_out_value = r_out_value;
        n_out_end   = r_out_end;
        mem_we      = 1'b0;
        mem_waddr   = r_cmd.addr;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = i_cmd.addr;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + ADDR_W'(1);
                if (r_clr_cnt == ADDR_W'(STORE_SIZE - 1)) begin
                    n_state   = S_IDLE;
                    n_init    = 1'b0;
                    n_clr_cnt = '0;
                end
            end
            S_IDLE: begin
                if (o_pop) begin
                    n_cmd = i_cmd;
                    unique case (i_cmd.op) inside
                        OP_SET_BIT, OP_CLR_BIT: begin
                            mem_re  = 1'b1;
                            n_state = S_PIX;
                        end
                        OP_WRITE_BYTE: begin
                            mem_we    = 1'b1;
                            mem_waddr = i_cmd.addr;
                            mem_wdata = i_cmd.data;
                        end
                        OP_CLEAR: begin
                            n_clr_cnt = '0;
                            n_state   = S_CLEAR;
                        end
                        OP_EMIT_CMD: begin
                            n_out_valid = 1'b1;
                            n_out_ctrl  = CTRL_CMD;
                            n_out_value = i_cmd.data;
                            n_out_end   = 1'b0;
                        end
                        OP_EMIT_DATA: begin
                            mem_re  = 1'b1;
                            n_state = S_DATA;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PIX: begin
                mem_we    = 1'b1;
                mem_wdata = (r_cmd.op == OP_SET_BIT) ? (r_rd_data | bit_mask)
                                                     : (r_rd_data & ~bit_mask);
                n_state   = S_IDLE;
            end
            S_DATA: begin
                n_out_valid = 1'b1;
                n_out_ctrl  = CTRL_DATA;
                n_out_value = r_rd_data;
                n_out_end   = r_cmd.last;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_init      <= 1'b1;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
        end
        r_cmd       <= n_cmd;
        r_out_ctrl  <= n_out_ctrl;
        r_out_value <= n_out_value;
        r_out_end   <= n_out_end;
    end

endmodule

// File: hw/rtl/monochrome_page_framebuffer_top.sv
// a command byte passes the queue and output register; a data byte also the read register
// throughput: the command queue takes one transfer a cycle unless full or in the reset sweep;
//   the back end pops no new item while a pixel draw or data byte is in S_PIX or S_DATA
// clear walks the 1024-byte store one byte a cycle
// reset: synchronous, active low; afterwards the same sweep zeroes the store
//   with input ready held low, and the refresh position restarts at page 0
module monochrome_page_framebuffer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpfb_in_if.sink    i_in,
    mpfb_out_if.source o_out
);
    import mpfb_pkg::*;

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic init_busy;
    t_cmd push_cmd;
    t_cmd q_cmd;

    mpfb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_full      (q_full),
        .i_init_busy (init_busy),
        .o_push      (q_push),
        .o_cmd       (push_cmd)
    );

    mpfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    mpfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_init_busy (init_busy),
        .o_out       (o_out)
    );

endmodule

// File: hw/rtl/mpfb_checker.sv
`include "monochrome_page_framebuffer_top_macros.svh"

module mpfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_control_byte,
    input logic [7:0] i_value,
    input logic       i_frame_end
);
    import mpfb_pkg::*;

    logic        out_stall;
    logic        out_end;
    logic        ctrl_ok;
    logic [15:0] out_word;

    assign out_stall = i_out_valid && !i_out_ready;
    assign out_end   = i_out_valid && i_frame_end;
    assign ctrl_ok   = (i_control_byte == CTRL_CMD) || (i_control_byte == CTRL_DATA);
    assign out_word  = {i_control_byte, i_value, i_frame_end};

    // no input transfer right after reset while the store is swept
    `MPFB_ASSERT_NOW(a_no_accept_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !i_in_ready, "early ready")

    `MPFB_ASSERT_NOW(a_ctrl_code, i_clk, i_rst_n, i_out_valid, ctrl_ok, "bad control byte")

    `MPFB_ASSERT_NOW(a_end_is_data, i_clk, i_rst_n, out_end, i_control_byte == CTRL_DATA, "end on cmd")

    `MPFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_word), "unstable")

endmodule

bind monochrome_page_framebuffer_top mpfb_checker u_mpfb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_control_byte (o_out.control_byte),
    .i_value        (o_out.value),
    .i_frame_end    (o_out.frame_end)
);

// File: tb/monochrome_page_framebuffer_top_tb.sv
`timescale 1ns / 100ps

module monochrome_page_framebuffer_top_tb;
    import mpfb_pkg::*;

    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 1680;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] dot;
        logic [2:0] page;
        logic [7:0] bitmap_byte;
    } t_draw_req;

    typedef struct packed {
        logic [6:0] ctrl;
        logic [7:0] value;
        logic       frame_end;
    } t_bus_byte;

    typedef struct {
        t_draw_req req;
        bit        typed;
        t_bus_byte result;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    mpfb_in_if  in_bus();
    mpfb_out_if out_bus();

    monochrome_page_framebuffer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // shadow of the display memory and the refresh scan position
    logic [7:0] frame_copy [STORE_SIZE];
    int         scan_page;
    int         scan_step;

    t_bus_byte  pending_bus_bytes[$];
    t_stim_row  directed_rows[$];
    int         mismatch_count = 0;
    int         src_calm = 0;
    int         sink_calm = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // random wait before a transfer, with occasional runs of back-to-back transfers
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
        end
        return $urandom_range(0, 5);
    endfunction

    function automatic void reset_frame_copy();
        foreach (frame_copy[i]) begin
            frame_copy[i] = 8'h00;
        end
        scan_page = 0;
        scan_step = 0;
    endfunction

    function automatic void apply_request(input t_draw_req req, output bit has_byte,
                                          output t_bus_byte b);
        int         idx;
        int         col;
        logic [7:0] flipped;
        has_byte = 1'b0;
        b = '0;
        case (req.mode)
            MODE_DRAW: begin
                if (req.x < COLUMNS && req.y < ROWS && (req.dot == 8'd0 || req.dot == 8'd1)) begin
                    idx = (req.y >> 3) * COLUMNS + req.x;
                    frame_copy[idx][req.y[2:0]] = req.dot[0];
                end
            end
            MODE_CLEAR: begin
                foreach (frame_copy[i]) begin
                    frame_copy[i] = 8'h00;
                end
            end
            MODE_BITMAP: begin
                if (req.x < COLUMNS && req.page < PAGES) begin
                    for (int i = 0; i < 8; i++) begin
                        flipped[i] = req.bitmap_byte[7-i];
                    end
                    frame_copy[req.page * COLUMNS + req.x] = flipped;
                end
            end
            MODE_REFRESH: begin
                has_byte = 1'b1;
                if (scan_step == 0) begin
                    b.ctrl  = CTRL_CMD;
                    b.value = CMD_PAGE_BASE + 8'(scan_page);
                end else if (scan_step == 1) begin
                    b.ctrl  = CTRL_CMD;
                    b.value = CMD_COL_HIGH;
                end else if (scan_step == 2) begin
                    b.ctrl  = CTRL_CMD;
                    b.value = CMD_COL_LOW;
                end else begin
                    col = scan_step - 3;
                    b.ctrl = CTRL_DATA;
                    b.value = frame_copy[scan_page * COLUMNS + col];
                    b.frame_end = (col == COLUMNS - 1) && (scan_page == PAGES - 1);
                end
                if (scan_step >= COLUMNS + 2) begin
                    scan_step = 0;
                    scan_page = (scan_page + 1) % PAGES;
                end else begin
                    scan_step++;
                end
            end
        endcase
    endfunction

    function automatic void add_row(input t_mode m, input logic [7:0] x, input logic [7:0] y,
                                    input logic [7:0] dot, input logic [2:0] page,
                                    input logic [7:0] bmp, input bit typed = 1'b0,
                                    input logic [6:0] ctrl = 7'h00,
                                    input logic [7:0] value = 8'h00,
                                    input logic fend = 1'b0);
        t_stim_row row;
        row.req    = '{m, x, y, dot, page, bmp};
        row.typed  = typed;
        row.result = '{ctrl, value, fend};
        directed_rows.push_back(row);
    endfunction

    function automatic t_draw_req random_request();
        t_draw_req r;
        int        pick;
        r.x           = 8'($urandom);
        r.y           = 8'($urandom);
        r.dot         = 8'($urandom);
        r.page        = 3'($urandom);
        r.bitmap_byte = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            r.mode = MODE_REFRESH;
        end else if (pick < 84) begin
            r.mode = MODE_DRAW;
            if ($urandom_range(0, 7) != 0) begin
                r.x   = 8'($urandom_range(0, COLUMNS - 1));
                r.y   = 8'($urandom_range(0, ROWS - 1));
                r.dot = 8'($urandom_range(0, 1));
            end
        end else if (pick < 98) begin
            r.mode = MODE_BITMAP;
            if ($urandom_range(0, 7) != 0) begin
                r.x = 8'($urandom_range(0, COLUMNS - 1));
            end
        end else begin
            r.mode = MODE_CLEAR;
        end
        return r;
    endfunction

    task automatic send_request(input t_draw_req req, input bit typed, input t_bus_byte typed_byte);
        int        gap;
        bit        has_byte;
        t_bus_byte predicted;
        gap = pick_wait(src_calm);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.mode        <= req.mode;
        in_bus.x           <= req.x;
        in_bus.y           <= req.y;
        in_bus.dot         <= req.dot;
        in_bus.page        <= req.page;
        in_bus.bitmap_byte <= req.bitmap_byte;
        do @(posedge i_clk); while (!in_bus.ready);
        apply_request(req, has_byte, predicted);
        if (has_byte) begin
            pending_bus_bytes.push_back(typed ? typed_byte : predicted);
        end
    endtask

    initial begin : stimulus
        t_draw_req req;
        i_rst_n            <= 1'b0;
        in_bus.valid       <= 1'b0;
        in_bus.mode        <= MODE_DRAW;
        in_bus.x           <= 8'h00;
        in_bus.y           <= 8'h00;
        in_bus.dot         <= 8'h00;
        in_bus.page        <= 3'h0;
        in_bus.bitmap_byte <= 8'h00;
        reset_frame_copy();

        // scan restarts with the page 0 position commands
        add_row(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 3'h0, 8'h00, 1'b1, CTRL_CMD, CMD_PAGE_BASE);
        add_row(MODE_REFRESH, 8'hFF, 8'hFF, 8'hFF, 3'h7, 8'hFF, 1'b1, CTRL_CMD, CMD_COL_HIGH);
        add_row(MODE_REFRESH, 8'h5A, 8'hA5, 8'h01, 3'h2, 8'h3C, 1'b1, CTRL_CMD, CMD_COL_LOW);
        add_row(MODE_DRAW, 8'd0, 8'd0, 8'd1, 3'h0, 8'h00);
        add_row(MODE_DRAW, 8'd127, 8'd63, 8'd1, 3'h7, 8'hFF);
        add_row(MODE_DRAW, 8'd128, 8'd0, 8'd1, 3'h0, 8'h00);
        add_row(MODE_DRAW, 8'd255, 8'd255, 8'd1, 3'h0, 8'h00);
        add_row(MODE_DRAW, 8'd1, 8'd64, 8'd1, 3'h0, 8'h00);
        add_row(MODE_DRAW, 8'd2, 8'd5, 8'd2, 3'h0, 8'h00);
        add_row(MODE_DRAW, 8'd2, 8'd5, 8'd255, 3'h0, 8'h00);
        add_row(MODE_DRAW, 8'd3, 8'd7, 8'd1, 3'h0, 8'h00);
        add_row(MODE_DRAW, 8'd3, 8'd7, 8'd0, 3'h0, 8'h00);
        add_row(MODE_BITMAP, 8'd1, 8'd0, 8'd0, 3'h0, 8'h80);
        add_row(MODE_BITMAP, 8'd128, 8'd0, 8'd0, 3'h0, 8'hFF);
        add_row(MODE_BITMAP, 8'd255, 8'd0, 8'd0, 3'h7, 8'hFF);
        add_row(MODE_BITMAP, 8'd127, 8'd0, 8'd0, 3'h7, 8'hFF);
        add_row(MODE_BITMAP, 8'd4, 8'd0, 8'd0, 3'h0, 8'h00);
        add_row(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 3'h0, 8'h00);
        add_row(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 3'h0, 8'h00);
        add_row(MODE_CLEAR, 8'hFF, 8'hFF, 8'hFF, 3'h7, 8'hFF);
        add_row(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 3'h0, 8'h00, 1'b1, CTRL_DATA, 8'h00);
        add_row(MODE_DRAW, 8'd3, 8'd0, 8'd1, 3'h0, 8'h00);
        add_row(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 3'h0, 8'h00);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);
        end
        repeat (RANDOM_ITEMS) begin
            req = random_request();
            send_request(req, 1'b0, '0);
        end
        in_bus.valid <= 1'b0;

        while (pending_bus_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : bus_sink
        int        gap;
        t_bus_byte got;
        t_bus_byte want;
        out_bus.ready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            gap = pick_wait(sink_calm);
            if (gap > 0) begin
                out_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!out_bus.valid);
            got = '{out_bus.control_byte, out_bus.value, out_bus.frame_end};
            if (pending_bus_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte ctrl %0h value %0h end %0b",
                                          got.ctrl, got.value, got.frame_end));
            end else begin
                want = pending_bus_bytes.pop_front();
                if (got.ctrl !== want.ctrl) begin
                    report_mismatch($sformatf("control byte %0h, want %0h", got.ctrl, want.ctrl));
                end
                if (got.value !== want.value) begin
                    report_mismatch($sformatf("value %0h, want %0h", got.value, want.value));
                end
                if (got.frame_end !== want.frame_end) begin
                    report_mismatch($sformatf("frame end %0b, want %0b",
                                              got.frame_end, want.frame_end));
                end
            end
        end
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/mpfb_pkg.sv
hw/rtl/mpfb_in_if.sv
hw/rtl/mpfb_out_if.sv
hw/rtl/mpfb_front.sv
hw/rtl/mpfb_queue.sv
hw/rtl/mpfb_back.sv
hw/rtl/monochrome_page_framebuffer_top.sv
hw/rtl/mpfb_checker.sv
tb/monochrome_page_framebuffer_top_tb.sv
